[rtl/box_plane_side_test_assert.svh]
// assertion macros shared by the box/plane side test rtl
// no dependencies; compiled out when SYNTHESIS is defined
`ifndef BOX_PLANE_SIDE_TEST_ASSERT_SVH
`define BOX_PLANE_SIDE_TEST_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define BPST_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bpst same-cycle check failed");
// next-cycle implication
`define BPST_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bpst next-cycle check failed");
`else
`define BPST_ASSERT_NOW(label, clk, rst, ante, cons)
`define BPST_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

[rtl/bpst_pkg.sv]
// shared types and constants for the box/plane side test
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package bpst_pkg;

   // fixed field widths
   localparam int NORM_W = 16;
   localparam int SIGN_W = 3;
   localparam int MASK_W = 2;
   localparam int AXES   = 3;

   // side mask bit positions
   localparam int MASK_FRONT_BIT = 0;
   localparam int MASK_BACK_BIT  = 1;

   typedef logic [NORM_W-1:0]           norm_type;
   typedef logic [AXES-1:0][NORM_W-1:0] norm_vec_type;
   typedef logic [MASK_W-1:0]           mask_type;

endpackage

`default_nettype wire

[rtl/box_plane_side_test.sv]
// top level of the box/plane side test: four-stage pipeline
// depends on bpst_pkg, bpst_corner, bpst_dot, bpst_cmp, box_plane_side_test_assert.svh
//
// Classifies an axis-aligned box against a plane. Each item on the req_ stream
// carries both box corners, the plane normal and distance in req_tdata and the
// 3-bit sign code in req_tuser. Each result on the rsp_ stream is a 2-bit mask:
// bit 0 when the near corner lies on or in front of the plane, bit 1 when the
// far corner lies behind it. Products and sums are kept at full width.
// Pipeline: an accepted item passes through the corner select, multiply, sum
// and compare stages in that order, each its own register stage, the first one
// loaded at the accepting edge; its result then shows on rsp_tvalid.
// Throughput: one item per cycle; every stage holds its own valid bit, so a
// new item is taken every cycle while the result stream keeps up.
// When the receiver stalls, the stalled result stays on rsp_tdata and the
// stages behind it keep filling; req_tready falls once the first stage is
// full and blocked. Nothing is dropped or repeated.
// Reset clears all valid bits; no results are pending after reset.
`timescale 1ns / 1ps
`default_nettype none

module box_plane_side_test import bpst_pkg::*; #(
   parameter int COORD_BITS       = 32,
   parameter int NORMAL_FRAC_BITS = 14,
   localparam int ReqDataW = ((7 * COORD_BITS + AXES * NORM_W + 7) / 8) * 8,
   localparam int RspDataW = ((MASK_W + 7) / 8) * 8
) (
   input  logic                clock,
   input  logic                reset,
   // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
   // normal_x, normal_y, normal_z, plane_dist, zero fill
   input  logic [ReqDataW-1:0] req_tdata,
   // sign_code
   input  logic [SIGN_W-1:0]   req_tuser,
   input  logic                req_tvalid,
   output logic                req_tready,
   // side_mask, zero fill
   output logic [RspDataW-1:0] rsp_tdata,
   output logic                rsp_tvalid,
   input  logic                rsp_tready
);

   localparam int SumW  = COORD_BITS + NORM_W + 2;
   localparam int DistW = COORD_BITS + NORMAL_FRAC_BITS;
   localparam int NormBase = 2 * AXES * COORD_BITS;
   localparam int DistBase = NormBase + AXES * NORM_W;

   logic [AXES-1:0][COORD_BITS-1:0] box_min, box_max;
   norm_vec_type                    normal;
   logic [COORD_BITS-1:0]           plane_dist;

   logic                            s1_valid, s1_ready;
   logic [AXES-1:0][COORD_BITS-1:0] s1_near, s1_far;
   norm_vec_type                    s1_norm;
   logic [COORD_BITS-1:0]           s1_dist;

   logic                            s3_valid, s3_ready;
   logic signed [SumW-1:0]          s3_dot_near, s3_dot_far;
   logic signed [DistW-1:0]         s3_dist;

   mask_type                        side_mask;

   // unpack the request item
   always_comb begin
      for (int i = 0; i < AXES; i++) begin
         box_min[i] = req_tdata[i * COORD_BITS +: COORD_BITS];
         box_max[i] = req_tdata[(AXES + i) * COORD_BITS +: COORD_BITS];
         normal[i]  = req_tdata[NormBase + i * NORM_W +: NORM_W];
      end
      plane_dist = req_tdata[DistBase +: COORD_BITS];
   end

   // corner select
   bpst_corner #(
      .COORD_BITS (COORD_BITS)
   ) u_corner (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .box_min    (box_min),
      .box_max    (box_max),
      .normal     (normal),
      .plane_dist (plane_dist),
      .sign_code  (req_tuser),
      .out_valid  (s1_valid),
      .out_ready  (s1_ready),
      .near_c     (s1_near),
      .far_c      (s1_far),
      .normal_q   (s1_norm),
      .dist_q     (s1_dist)
   );

   // products and sums
   bpst_dot #(
      .COORD_BITS       (COORD_BITS),
      .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
   ) u_dot (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (s1_valid),
      .in_ready    (s1_ready),
      .near_c      (s1_near),
      .far_c       (s1_far),
      .normal      (s1_norm),
      .plane_dist  (s1_dist),
      .out_valid   (s3_valid),
      .out_ready   (s3_ready),
      .dot_near    (s3_dot_near),
      .dot_far     (s3_dot_far),
      .dist_scaled (s3_dist)
   );

   // compare and output register
   bpst_cmp #(
      .SUM_W  (SumW),
      .DIST_W (DistW)
   ) u_cmp (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (s3_valid),
      .in_ready    (s3_ready),
      .dot_near    (s3_dot_near),
      .dot_far     (s3_dot_far),
      .dist_scaled (s3_dist),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .side_mask   (side_mask)
   );

   assign rsp_tdata = RspDataW'(side_mask);

   // checks
   `include "box_plane_side_test_assert.svh"

   `BPST_ASSERT_NEXT(a_accept_fills_s1, clock, reset, req_tvalid && req_tready, s1_valid)
   `BPST_ASSERT_NOW(a_backpressure_when_full, clock, reset, !req_tready, s1_valid && !s1_ready)
   `BPST_ASSERT_NEXT(a_s1_holds_stalled, clock, reset, s1_valid && !s1_ready, s1_valid && $stable(s1_near))
   `BPST_ASSERT_NEXT(a_s3_holds_stalled, clock, reset, s3_valid && !s3_ready, s3_valid && $stable(s3_dot_far))

endmodule

`default_nettype wire

[rtl/bpst_corner.sv]
// stage 1: picks the near and far box corners from the sign code
// depends on bpst_pkg
`timescale 1ns / 1ps
`default_nettype none

module bpst_corner import bpst_pkg::*; #(
   parameter int COORD_BITS = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  logic [AXES-1:0][COORD_BITS-1:0]     box_min,
   input  logic [AXES-1:0][COORD_BITS-1:0]     box_max,
   input  norm_vec_type                        normal,
   input  logic [COORD_BITS-1:0]               plane_dist,
   input  logic [SIGN_W-1:0]                   sign_code,
   output logic                                out_valid,
   input  logic                                out_ready,
   output logic [AXES-1:0][COORD_BITS-1:0]     near_c,
   output logic [AXES-1:0][COORD_BITS-1:0]     far_c,
   output norm_vec_type                        normal_q,
   output logic [COORD_BITS-1:0]               dist_q
);

   logic                            valid_ff;
   logic [AXES-1:0][COORD_BITS-1:0] near_ff, near_in;
   logic [AXES-1:0][COORD_BITS-1:0] far_ff, far_in;
   norm_vec_type                    norm_ff;
   logic [COORD_BITS-1:0]           dist_ff;

   // stage takes a new item when empty or when it drains this cycle
   assign in_ready = !valid_ff || out_ready;

   // per-axis corner selection
   always_comb begin
      for (int i = 0; i < AXES; i++) begin
         if (sign_code[i]) begin
            near_in[i] = box_min[i];
            far_in[i]  = box_max[i];
         end else begin
            near_in[i] = box_max[i];
            far_in[i]  = box_min[i];
         end
      end
   end

   // valid bit
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         near_ff <= near_in;
         far_ff  <= far_in;
         norm_ff <= normal;
         dist_ff <= plane_dist;
      end
   end

   assign out_valid = valid_ff;
   assign near_c    = near_ff;
   assign far_c     = far_ff;
   assign normal_q  = norm_ff;
   assign dist_q    = dist_ff;

endmodule

`default_nettype wire

[rtl/bpst_dot.sv]
// stages 2 and 3: six products, then the two three-term dot products and the scaled plane distance
// depends on bpst_pkg
`timescale 1ns / 1ps
`default_nettype none

module bpst_dot import bpst_pkg::*; #(
   parameter int COORD_BITS       = 32,
   parameter int NORMAL_FRAC_BITS = 14,
   localparam int ProdW = COORD_BITS + NORM_W,
   localparam int SumW  = ProdW + 2,
   localparam int DistW = COORD_BITS + NORMAL_FRAC_BITS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   output logic                            in_ready,
   input  logic [AXES-1:0][COORD_BITS-1:0] near_c,
   input  logic [AXES-1:0][COORD_BITS-1:0] far_c,
   input  norm_vec_type                    normal,
   input  logic [COORD_BITS-1:0]           plane_dist,
   output logic                            out_valid,
   input  logic                            out_ready,
   output logic signed [SumW-1:0]          dot_near,
   output logic signed [SumW-1:0]          dot_far,
   output logic signed [DistW-1:0]         dist_scaled
);

   logic                       mul_valid_ff;
   logic                       mul_ready;
   logic signed [ProdW-1:0]    pn_ff [AXES];
   logic signed [ProdW-1:0]    pn_in [AXES];
   logic signed [ProdW-1:0]    pf_ff [AXES];
   logic signed [ProdW-1:0]    pf_in [AXES];
   logic [COORD_BITS-1:0]      mdist_ff;

   logic                       sum_valid_ff;
   logic signed [SumW-1:0]     dn_ff, dn_in;
   logic signed [SumW-1:0]     df_ff, df_in;
   logic signed [DistW-1:0]    ds_ff, ds_in;

   // multiply stage
   assign in_ready = !mul_valid_ff || mul_ready;

   always_comb begin
      for (int i = 0; i < AXES; i++) begin
         pn_in[i] = $signed(near_c[i]) * $signed(normal[i]);
         pf_in[i] = $signed(far_c[i]) * $signed(normal[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
      end else if (in_ready) begin
         mul_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         pn_ff    <= pn_in;
         pf_ff    <= pf_in;
         mdist_ff <= plane_dist;
      end
   end

   // sum stage
   assign mul_ready = !sum_valid_ff || out_ready;

   always_comb begin
      dn_in = SumW'(pn_ff[0]) + SumW'(pn_ff[1]) + SumW'(pn_ff[2]);
      df_in = SumW'(pf_ff[0]) + SumW'(pf_ff[1]) + SumW'(pf_ff[2]);
      ds_in = $signed({mdist_ff, {NORMAL_FRAC_BITS{1'b0}}});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_valid_ff <= 1'b0;
      end else if (mul_ready) begin
         sum_valid_ff <= mul_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mul_ready && mul_valid_ff) begin
         dn_ff <= dn_in;
         df_ff <= df_in;
         ds_ff <= ds_in;
      end
   end

   assign out_valid   = sum_valid_ff;
   assign dot_near    = dn_ff;
   assign dot_far     = df_ff;
   assign dist_scaled = ds_ff;

endmodule

`default_nettype wire

[rtl/bpst_cmp.sv]
// stage 4: compares both dot products with the scaled distance, output register
// depends on bpst_pkg
`timescale 1ns / 1ps
`default_nettype none

module bpst_cmp import bpst_pkg::*; #(
   parameter int SUM_W  = 50,
   parameter int DIST_W = 46,
   localparam int CmpW = ((SUM_W > DIST_W) ? SUM_W : DIST_W) + 1
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  logic signed [SUM_W-1:0]   dot_near,
   input  logic signed [SUM_W-1:0]   dot_far,
   input  logic signed [DIST_W-1:0]  dist_scaled,
   output logic                      out_valid,
   input  logic                      out_ready,
   output mask_type                  side_mask
);

   logic                   valid_ff;
   mask_type               mask_ff, mask_in;
   logic signed [CmpW-1:0] near_ext, far_ext, dist_ext;

   assign in_ready = !valid_ff || out_ready;

   // exact signed compare at a common width
   always_comb begin
      near_ext = CmpW'(dot_near);
      far_ext  = CmpW'(dot_far);
      dist_ext = CmpW'(dist_scaled);
      mask_in                 = '0;
      mask_in[MASK_FRONT_BIT] = (near_ext >= dist_ext);
      mask_in[MASK_BACK_BIT]  = (far_ext < dist_ext);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         mask_ff <= mask_in;
      end
   end

   assign out_valid = valid_ff;
   assign side_mask = mask_ff;

endmodule

`default_nettype wire
